// ===== hdl/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg
// Types and codes shared by the rule table lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package prc_pkg;

  localparam int REQ_W    = 2;
  localparam int PROTO_W  = 8;
  localparam int PORT_W   = 16;
  localparam int RIDX_W   = 5;
  localparam int STATUS_W = 3;

  localparam int MAX_RESULTS = 32;
  localparam int HIT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STS_MATCH    = 3'd0;
  localparam logic [STATUS_W-1:0] STS_NOMATCH  = 3'd1;
  localparam logic [STATUS_W-1:0] STS_APPENDED = 3'd2;
  localparam logic [STATUS_W-1:0] STS_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] STS_CLEARED  = 3'd4;

  typedef struct packed {
    logic [PROTO_W-1:0] proto;
    logic               wild;
    logic [PORT_W-1:0]  port;
  } rule_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [PROTO_W-1:0] proto;
    logic               wild_port;
    logic [PORT_W-1:0]  port;
  } req_t;

  typedef struct packed {
    logic [RIDX_W-1:0]   rule_index;
    logic [STATUS_W-1:0] status;
    logic                last;
  } rsp_t;

  typedef struct packed {
    logic valid;
    rsp_t rsp;
  } emit_t;

endpackage

`default_nettype wire

// ===== hdl/prc_if.sv =====
// ----------------------------------------------------------------------------
// prc_if
// Request and result channel interfaces for the rule table lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

interface prc_req_if;
  logic                         valid;
  logic                         ready;
  logic [prc_pkg::REQ_W-1:0]    req_type;
  logic [prc_pkg::PROTO_W-1:0]  proto;
  logic                         wild_port;
  logic [prc_pkg::PORT_W-1:0]   port;

  modport source (output valid, output req_type, output proto, output wild_port,
                  output port, input ready);
  modport sink (input valid, input req_type, input proto, input wild_port,
                input port, output ready);
endinterface

interface prc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [prc_pkg::RIDX_W-1:0]    rule_index;
  logic [prc_pkg::STATUS_W-1:0]  status;
  logic                          last;

  modport source (output valid, output rule_index, output status, output last,
                  input ready);
  modport sink (input valid, input rule_index, input status, input last,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/port_rule_candidate_lookup_top.sv =====
// ----------------------------------------------------------------------------
// port_rule_candidate_lookup_top
// Protocol/port rule table with clear, append and candidate lookup requests.
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  in_req   in   req_type, proto, wild_port, port
//  out_rsp  out  rule_index, status, last
//
//  Clear and append hold their result in resp_r until the output is free.
//  A lookup reads the rule memory once per stored rule in each of its two
//  passes, through the single read port.
//  Reset clears the rule count; rule entries are undefined until appended.
//  A stalled result holds the output register; the scan pauses when a second
//  match is pending behind it. Requests are taken only between lookups.
// ----------------------------------------------------------------------------
`default_nettype none

module port_rule_candidate_lookup_top #(
  parameter int RULE_COUNT = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  prc_req_if.sink    in_req,
  prc_rsp_if.source  out_rsp
);

  localparam int IDX_W = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;

  prc_pkg::req_t   req;
  prc_pkg::rule_t  wr_data;
  prc_pkg::rule_t  rd_data;
  prc_pkg::emit_t  emit;
  prc_pkg::rsp_t   rsp;
  logic            wr_en;
  logic            rd_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic            out_free;

  assign req = '{req_type: in_req.req_type, proto: in_req.proto,
                 wild_port: in_req.wild_port, port: in_req.port};

  prc_ctrl #(.RULE_COUNT(RULE_COUNT)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .in_req   (req),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .out_free (out_free),
    .emit     (emit)
  );

  prc_rule_mem #(.RULE_COUNT(RULE_COUNT)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  prc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .out_free  (out_free),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .out_rsp   (rsp)
  );

  assign out_rsp.rule_index = rsp.rule_index;
  assign out_rsp.status     = rsp.status;
  assign out_rsp.last       = rsp.last;

endmodule

`default_nettype wire

// ===== hdl/prc_rule_mem.sv =====
// ----------------------------------------------------------------------------
// prc_rule_mem
// Rule storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_rule_mem #(
  parameter  int RULE_COUNT = 32,
  localparam int IDX_W      = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [IDX_W-1:0]     wr_addr,
  input  wire prc_pkg::rule_t       wr_data,
  input  wire logic                 rd_en,
  input  wire logic [IDX_W-1:0]     rd_addr,
  output prc_pkg::rule_t            rd_data
);

  prc_pkg::rule_t mem [RULE_COUNT];
  prc_pkg::rule_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hdl/prc_out_reg.sv =====
// ----------------------------------------------------------------------------
// prc_out_reg
// Result output register; decouples the scan from downstream stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_out_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire prc_pkg::emit_t emit,
  output logic                out_free,
  output logic                out_valid,
  input  wire logic           out_ready,
  output prc_pkg::rsp_t       out_rsp
);

  logic           valid_r;
  logic           valid_nxt;
  prc_pkg::rsp_t  rsp_r;

  assign out_free  = !valid_r || out_ready;
  assign valid_nxt = emit.valid ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      rsp_r <= emit.rsp;
    end
  end

  assign out_valid = valid_r;
  assign out_rsp   = rsp_r;

endmodule

`default_nettype wire

// ===== hdl/prc_ctrl.sv =====
// ----------------------------------------------------------------------------
// prc_ctrl
// Request sequencer: table updates and the two-pass lookup scan.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_ctrl #(
  parameter  int RULE_COUNT = 32,
  localparam int IDX_W      = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire prc_pkg::req_t     in_req,
  output logic                   wr_en,
  output logic [IDX_W-1:0]       wr_addr,
  output prc_pkg::rule_t         wr_data,
  output logic                   rd_en,
  output logic [IDX_W-1:0]       rd_addr,
  input  wire prc_pkg::rule_t    rd_data,
  input  wire logic              out_free,
  output prc_pkg::emit_t         emit
);

  localparam int CNT_W = $clog2(RULE_COUNT + 1);
  localparam int EXT_W = IDX_W + prc_pkg::RIDX_W;
  localparam int HIT_W = prc_pkg::HIT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [CNT_W-1:0]             total_r, total_nxt;
  logic [CNT_W-1:0]             addr_r, addr_nxt;
  logic                         pass_r, pass_nxt;
  logic                         ev_valid_r, ev_valid_nxt;
  logic                         ev_pass_r, ev_pass_nxt;
  logic [IDX_W-1:0]             ev_idx_r, ev_idx_nxt;
  logic                         pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0]             pend_idx_r, pend_idx_nxt;
  logic [HIT_W-1:0]             hits_r, hits_nxt;
  logic [prc_pkg::PROTO_W-1:0]  key_proto_r, key_proto_nxt;
  logic [prc_pkg::PORT_W-1:0]   key_port_r, key_port_nxt;
  prc_pkg::rsp_t                resp_r, resp_nxt;

  logic              accept;
  logic              issue;
  logic              hit;
  logic              stall;
  logic              exhausted;
  logic              capped;
  logic [EXT_W-1:0]  pend_ext;
  logic [EXT_W-1:0]  total_ext;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign capped    = (hits_r == HIT_W'(prc_pkg::MAX_RESULTS));
  assign exhausted = pass_r && (addr_r >= total_r);
  assign pend_ext  = EXT_W'(pend_idx_r);
  assign total_ext = EXT_W'(total_r[IDX_W-1:0]);

  assign hit = (state_r == ST_SCAN) && ev_valid_r && !capped &&
               (rd_data.proto == key_proto_r) &&
               (ev_pass_r ? rd_data.wild
                          : (!rd_data.wild && (rd_data.port == key_port_r)));
  assign stall = hit && pend_valid_r && !out_free;
  assign issue = (state_r == ST_SCAN) && !stall && !capped && (addr_r < total_r);

  assign rd_en   = issue;
  assign rd_addr = addr_r[IDX_W-1:0];

  assign wr_en   = accept && (in_req.req_type == prc_pkg::REQ_APPEND) &&
                   (total_r != CNT_W'(RULE_COUNT));
  assign wr_addr = total_r[IDX_W-1:0];
  assign wr_data = '{proto: in_req.proto, wild: in_req.wild_port,
                     port: in_req.wild_port ? '0 : in_req.port};

  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    addr_nxt       = addr_r;
    pass_nxt       = pass_r;
    ev_valid_nxt   = ev_valid_r;
    ev_pass_nxt    = ev_pass_r;
    ev_idx_nxt     = ev_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    hits_nxt       = hits_r;
    key_proto_nxt  = key_proto_r;
    key_port_nxt   = key_port_r;
    resp_nxt       = resp_r;
    emit           = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req.req_type)
            prc_pkg::REQ_CLEAR: begin
              total_nxt = '0;
              resp_nxt  = '{rule_index: '0, status: prc_pkg::STS_CLEARED, last: 1'b1};
              state_nxt = ST_RESP;
            end
            prc_pkg::REQ_APPEND: begin
              if (total_r == CNT_W'(RULE_COUNT)) begin
                resp_nxt = '{rule_index: '0, status: prc_pkg::STS_FULL, last: 1'b1};
              end else begin
                total_nxt = total_r + CNT_W'(1);
                resp_nxt  = '{rule_index: total_ext[prc_pkg::RIDX_W-1:0],
                              status: prc_pkg::STS_APPENDED, last: 1'b1};
              end
              state_nxt = ST_RESP;
            end
            prc_pkg::REQ_LOOKUP: begin
              key_proto_nxt  = in_req.proto;
              key_port_nxt   = in_req.port;
              addr_nxt       = '0;
              pass_nxt       = 1'b0;
              ev_valid_nxt   = 1'b0;
              pend_valid_nxt = 1'b0;
              hits_nxt       = '0;
              state_nxt      = ST_SCAN;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (!stall) begin
          if (hit) begin
            emit.valid     = pend_valid_r;
            emit.rsp       = '{rule_index: pend_ext[prc_pkg::RIDX_W-1:0],
                               status: prc_pkg::STS_MATCH, last: 1'b0};
            pend_valid_nxt = 1'b1;
            pend_idx_nxt   = ev_idx_r;
            hits_nxt       = hits_r + HIT_W'(1);
          end
          ev_valid_nxt = issue;
          ev_pass_nxt  = pass_r;
          ev_idx_nxt   = addr_r[IDX_W-1:0];
          if (issue) begin
            addr_nxt = addr_r + CNT_W'(1);
          end else if (!pass_r) begin
            pass_nxt = 1'b1;
            addr_nxt = '0;
          end
          if (capped || exhausted) begin
            ev_valid_nxt = 1'b0;
            state_nxt    = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        if (out_free) begin
          emit.valid = 1'b1;
          if (pend_valid_r) begin
            emit.rsp = '{rule_index: pend_ext[prc_pkg::RIDX_W-1:0],
                         status: prc_pkg::STS_MATCH, last: 1'b1};
          end else begin
            emit.rsp = '{rule_index: '0, status: prc_pkg::STS_NOMATCH, last: 1'b1};
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          emit.valid = 1'b1;
          emit.rsp   = resp_r;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      total_r      <= '0;
      ev_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      hits_r       <= '0;
      addr_r       <= '0;
      pass_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      total_r      <= total_nxt;
      ev_valid_r   <= ev_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      hits_r       <= hits_nxt;
      addr_r       <= addr_nxt;
      pass_r       <= pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_pass_r   <= ev_pass_nxt;
    ev_idx_r    <= ev_idx_nxt;
    pend_idx_r  <= pend_idx_nxt;
    key_proto_r <= key_proto_nxt;
    key_port_r  <= key_port_nxt;
    resp_r      <= resp_nxt;
  end

endmodule

`default_nettype wire
